### design/vgts_pkg.sv
// shared types and constants for the voxel grid sampler
`default_nettype none
package vgts_pkg;
   localparam logic [1:0] FUNC_WRITE  = 2'd0;
   localparam logic [1:0] FUNC_READ   = 2'd1;
   localparam logic [1:0] FUNC_SAMPLE = 2'd2;
   localparam logic [1:0] FUNC_CLEAR  = 2'd3;

   localparam logic [2:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [2:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [2:0] CSR_INV_X    = 3'd3;
   localparam logic [2:0] CSR_INV_Y    = 3'd4;
   localparam logic [2:0] CSR_INV_Z    = 3'd5;

   localparam logic [31:0] INV_RESET = 32'd65536;

   typedef struct packed {
      logic [1:0]  func;
      logic [9:0]  x_index;
      logic [9:0]  y_index;
      logic [9:0]  z_index;
      logic [31:0] value;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
   } req_type;

   typedef struct packed {
      logic [31:0] density;
      logic        in_grid;
      logic [31:0] max_density;
   } rsp_type;
endpackage
`default_nettype wire

### design/vgts_if.sv
// valid/ready channel interface
`default_nettype none
interface vgts_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### design/voxel_grid_trilinear_sampler.sv
// top level: voxel store, sequencer and interpolation datapath
//
//  channel | dir | handshake          | payload
//  req     | in  | req.valid/ready    | func, indices, value, pos_x/y/z
//  rsp     | out | rsp.valid/ready    | density, in_grid, max_density
//  csr     | in  | csr_write          | csr_index, csr_data
//
// one item at a time. write/read: store access, then capture; sample: the axis
// stages, the corner fetches on the single store port, then the seven lerps on
// one shared lerp unit. clear sweeps the store, one word a cycle; after reset
// the same sweep runs, with no result, before the first item is taken.
// the result sits in an output register until taken, then the block returns
// to idle; no new item is accepted while it waits.
`default_nettype none
module voxel_grid_trilinear_sampler #(
   parameter int GRID_X    = 32,
   parameter int GRID_Y    = 32,
   parameter int GRID_Z    = 32,
   parameter int FRAC_BITS = 16
) (
   input  wire         clock,
   input  wire         reset,
   vgts_if.sink        req,
   vgts_if.source      rsp,
   input  wire         csr_write,
   input  wire  [2:0]  csr_index,
   input  wire  [31:0] csr_data
);
   localparam int XW    = (GRID_X > 1) ? $clog2(GRID_X) : 1;
   localparam int YW    = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
   localparam int ZW    = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
   localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
   localparam int AW    = $clog2(CELLS);

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b00000001,
      ST_IDLE  = 8'b00000010,
      ST_AXIS  = 8'b00000100,
      ST_FETCH = 8'b00001000,
      ST_LERP  = 8'b00010000,
      ST_RDWT  = 8'b00100000,
      ST_DONE  = 8'b01000000,
      ST_OUT   = 8'b10000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [31:0] origin_ff [3];
   logic [31:0] inv_ff [3];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            origin_ff[i] <= '0;
            inv_ff[i]    <= vgts_pkg::INV_RESET;
         end
      end else if (csr_write) begin
         unique case (csr_index)
            vgts_pkg::CSR_ORIGIN_X: origin_ff[0] <= csr_data;
            vgts_pkg::CSR_ORIGIN_Y: origin_ff[1] <= csr_data;
            vgts_pkg::CSR_ORIGIN_Z: origin_ff[2] <= csr_data;
            vgts_pkg::CSR_INV_X:    inv_ff[0]    <= csr_data;
            vgts_pkg::CSR_INV_Y:    inv_ff[1]    <= csr_data;
            vgts_pkg::CSR_INV_Z:    inv_ff[2]    <= csr_data;
            default: ;
         endcase
      end
   end

   // captured request
   vgts_pkg::req_type item_ff;
   logic [31:0] peak_ff, peak_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [AW:0] clr_ff, clr_in;
   // a clear beat owes a result at the end of the sweep, the reset sweep does not
   logic        owed_ff, owed_in;

   // axis units
   logic okx, oky, okz;
   logic [XW-1:0] x0, x1;
   logic [YW-1:0] y0, y1;
   logic [ZW-1:0] z0, z1;
   logic [FRAC_BITS-1:0] tx, ty, tz;
   vgts_axis #(.GRID(GRID_X), .FRAC_BITS(FRAC_BITS), .IW(XW)) u_ax (
      .clock, .pos_in(item_ff.pos_x), .origin_in(origin_ff[0]), .inv_in(inv_ff[0]),
      .ok_out(okx), .i0_out(x0), .i1_out(x1), .t_out(tx));
   vgts_axis #(.GRID(GRID_Y), .FRAC_BITS(FRAC_BITS), .IW(YW)) u_ay (
      .clock, .pos_in(item_ff.pos_y), .origin_in(origin_ff[1]), .inv_in(inv_ff[1]),
      .ok_out(oky), .i0_out(y0), .i1_out(y1), .t_out(ty));
   vgts_axis #(.GRID(GRID_Z), .FRAC_BITS(FRAC_BITS), .IW(ZW)) u_az (
      .clock, .pos_in(item_ff.pos_z), .origin_in(origin_ff[2]), .inv_in(inv_ff[2]),
      .ok_out(okz), .i0_out(z0), .i1_out(z1), .t_out(tz));

   // voxel store: one port, registered read
   logic [31:0] mem [CELLS];
   logic [31:0] rdata_ff;
   logic        mem_we;
   logic [AW-1:0] mem_addr;
   logic [31:0] mem_wdata;
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      rdata_ff <= mem[mem_addr];
   end

   function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] xi,
         input logic [YW-1:0] yi, input logic [ZW-1:0] zi);
      logic [31:0] a;
      a = 32'(xi) + 32'(GRID_X) * (32'(yi) + 32'(GRID_Y) * 32'(zi));
      return a[AW-1:0];
   endfunction

   logic inside_idx;
   assign inside_idx = (32'(item_ff.x_index) < 32'(GRID_X)) &&
                       (32'(item_ff.y_index) < 32'(GRID_Y)) &&
                       (32'(item_ff.z_index) < 32'(GRID_Z));

   // corner fetch order: cnt bit0 = x, bit1 = y, bit2 = z
   logic [AW-1:0] fetch_addr;
   always_comb begin
      fetch_addr = cell_addr(cnt_ff[0] ? x1 : x0, cnt_ff[1] ? y1 : y0, cnt_ff[2] ? z1 : z0);
   end

   // corner and intermediate values
   logic signed [35:0] val_ff [8];
   logic signed [35:0] lerp_a, lerp_b, lerp_y;
   logic [FRAC_BITS-1:0] lerp_t;
   vgts_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
      .clock, .a_in(lerp_a), .b_in(lerp_b), .t_in(lerp_t), .y_out(lerp_y));

   // lerp sequencing step: even counts issue op cnt/2, odd counts store result
   logic [2:0] lerp_op;
   assign lerp_op = cnt_ff[3:1];

   // the lerp unit must see the op index, not the raw count
   logic [2:0] sched_sel;
   assign sched_sel = lerp_op;

   // lerp schedule: ops 0..3 x pairs, 4..5 y pairs, 6 z; each result is registered and lands in the next cycle
   always_comb begin
      unique case (sched_sel)
         3'd0: begin lerp_a = val_ff[0]; lerp_b = val_ff[1]; lerp_t = tx; end
         3'd1: begin lerp_a = val_ff[2]; lerp_b = val_ff[3]; lerp_t = tx; end
         3'd2: begin lerp_a = val_ff[4]; lerp_b = val_ff[5]; lerp_t = tx; end
         3'd3: begin lerp_a = val_ff[6]; lerp_b = val_ff[7]; lerp_t = tx; end
         3'd4: begin lerp_a = val_ff[0]; lerp_b = val_ff[1]; lerp_t = ty; end
         3'd5: begin lerp_a = val_ff[2]; lerp_b = val_ff[3]; lerp_t = ty; end
         default: begin lerp_a = val_ff[0]; lerp_b = val_ff[1]; lerp_t = tz; end
      endcase
   end

   logic in_ok;
   assign in_ok = okx && oky && okz;

   vgts_pkg::rsp_type out_ff, out_in;
   logic signed [35:0] sat;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      clr_in    = clr_ff;
      owed_in   = owed_ff;
      peak_in   = peak_ff;
      out_in    = out_ff;
      mem_we    = 1'b0;
      mem_addr  = cell_addr(XW'(item_ff.x_index), YW'(item_ff.y_index),
                            ZW'(item_ff.z_index));
      mem_wdata = item_ff.value;
      sat       = lerp_y;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff[AW-1:0];
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(CELLS - 1)) begin
               owed_in = 1'b0;
               if (owed_ff) begin
                  out_in   = '{density: '0, in_grid: 1'b0, max_density: peak_ff};
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_IDLE: begin
            if (req.valid) begin
               cnt_in = '0;
               priority case (req.payload.func)
                  vgts_pkg::FUNC_SAMPLE: state_in = ST_AXIS;
                  vgts_pkg::FUNC_CLEAR: begin
                     clr_in   = '0;
                     owed_in  = 1'b1;
                     peak_in  = '0;
                     state_in = ST_CLEAR;
                  end
                  default: state_in = ST_RDWT;
               endcase
            end
         end
         ST_RDWT: begin
            // write or read; read data comes the next cycle
            if (item_ff.func == vgts_pkg::FUNC_WRITE && inside_idx) begin
               mem_we = 1'b1;
               if ($signed(item_ff.value) > $signed(peak_ff)) peak_in = item_ff.value;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (item_ff.func == vgts_pkg::FUNC_WRITE)
               out_in = '{density: inside_idx ? item_ff.value : '0,
                          in_grid: inside_idx, max_density: peak_ff};
            else
               out_in = '{density: inside_idx ? rdata_ff : '0,
                          in_grid: inside_idx, max_density: peak_ff};
            state_in = ST_OUT;
         end
         ST_AXIS: begin
            // two axis pipeline stages, the second ending in the registered range check
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 4'd2) begin
               cnt_in = '0;
               if (in_ok) state_in = ST_FETCH;
               else begin
                  out_in   = '{density: '0, in_grid: 1'b0, max_density: peak_ff};
                  state_in = ST_OUT;
               end
            end
         end
         ST_FETCH: begin
            // address on cnt 0..7; the registered read data is captured into val_ff on cnt 1..8
            mem_addr = fetch_addr;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == 4'd8) begin
               cnt_in   = '0;
               state_in = ST_LERP;
            end
         end
         ST_LERP: begin
            // issue on even steps, collect on odd steps
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 4'd13) begin
               if (sat > 36'sd2147483647) sat = 36'sd2147483647;
               else if (sat < -36'sd2147483648) sat = -36'sd2147483648;
               out_in   = '{density: sat[31:0], in_grid: 1'b1, max_density: peak_ff};
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req.valid) item_ff <= req.payload;
      if (state_ff == ST_FETCH && cnt_ff != 4'd0)
         val_ff[3'(cnt_ff - 4'd1)] <= 36'($signed(rdata_ff));
      if (state_ff == ST_LERP && cnt_ff[0]) begin
         unique case (lerp_op)
            3'd0: val_ff[0] <= lerp_y;
            3'd1: val_ff[2] <= lerp_y;
            3'd2: val_ff[4] <= lerp_y;
            3'd3: val_ff[6] <= lerp_y;
            3'd4: val_ff[0] <= lerp_y;
            3'd5: val_ff[2] <= lerp_y;
            default: ;
         endcase
         // pack y-stage inputs next to each other
         if (lerp_op == 3'd3) begin
            val_ff[1] <= val_ff[2];
            val_ff[2] <= val_ff[4];
            val_ff[3] <= lerp_y;
         end
         if (lerp_op == 3'd5) val_ff[1] <= lerp_y;
      end
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         owed_ff  <= 1'b0;
         cnt_ff   <= '0;
         peak_ff  <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         owed_ff  <= owed_in;
         cnt_ff   <= cnt_in;
         peak_ff  <= peak_in;
      end
   end

   assign req.ready   = (state_ff == ST_IDLE);
   assign rsp.valid   = (state_ff == ST_OUT);
   assign rsp.payload = out_ff;
endmodule
`default_nettype wire

### design/vgts_lerp.sv
// one interpolation step per cycle: a + floor((b - a) * t / 2^frac), registered
`default_nettype none
module vgts_lerp #(
   parameter int FRAC_BITS = 16
) (
   input  wire                      clock,
   input  wire  signed [35:0]       a_in,
   input  wire  signed [35:0]       b_in,
   input  wire         [FRAC_BITS-1:0] t_in,
   output logic signed [35:0]       y_out
);
   logic signed [36:0] diff;
   logic signed [37+FRAC_BITS:0] prod;
   logic signed [37+FRAC_BITS:0] shifted;
   logic signed [35:0] y_ff, y_in;

   assign diff    = 37'(a_in) - 37'(b_in);
   // floor of (b-a)*t >> frac via arithmetic shift of (b-a)*t
   assign prod    = (38+FRAC_BITS)'(-diff) * $signed({1'b0, t_in});
   assign shifted = prod >>> FRAC_BITS;
   assign y_in    = 36'(37'(a_in) + 37'(shifted));

   always_ff @(posedge clock) begin
      y_ff <= y_in;
   end
   assign y_out = y_ff;
endmodule
`default_nettype wire

### design/vgts_axis.sv
// per-axis coordinate: (pos - origin) * inv, range check, split index/fraction
`default_nettype none
module vgts_axis #(
   parameter int GRID      = 32,
   parameter int FRAC_BITS = 16,
   parameter int IW        = 5
) (
   input  wire               clock,
   input  wire        [31:0] pos_in,
   input  wire        [31:0] origin_in,
   input  wire        [31:0] inv_in,
   output logic              ok_out,
   output logic [IW-1:0]     i0_out,
   output logic [IW-1:0]     i1_out,
   output logic [FRAC_BITS-1:0] t_out
);
   logic signed [32:0] rel_ff;
   logic        [31:0] inv_ff;
   logic        [64:0] prod;
   logic        [64:0] g;
   logic               ok_in;
   logic [IW-1:0]      i0_in, i1_in;
   logic [FRAC_BITS-1:0] t_in;
   logic               ok_ff;
   logic [IW-1:0]      i0_ff, i1_ff;
   logic [FRAC_BITS-1:0] t_ff;

   // stage one: subtraction
   always_ff @(posedge clock) begin
      rel_ff <= $signed({pos_in[31], pos_in}) - $signed({origin_in[31], origin_in});
      inv_ff <= inv_in;
   end

   // stage two: 33x32 product and range check
   assign prod = {32'd0, rel_ff[32:0]} * {33'd0, inv_ff};
   assign g    = prod >> FRAC_BITS;
   always_comb begin
      ok_in = 1'b1;
      i0_in = '0;
      t_in  = '0;
      if (inv_ff != 32'd0) begin
         if (rel_ff[32]) ok_in = 1'b0;
         else if (g > (65'(GRID - 1) << FRAC_BITS)) ok_in = 1'b0;
         i0_in = IW'(g >> FRAC_BITS);
         t_in  = g[FRAC_BITS-1:0];
      end
      i1_in = (32'(i0_in) + 32'd1 < 32'(GRID)) ? IW'(i0_in + 1'b1) : IW'(GRID - 1);
   end

   always_ff @(posedge clock) begin
      ok_ff <= ok_in;
      i0_ff <= i0_in;
      i1_ff <= i1_in;
      t_ff  <= t_in;
   end
   assign ok_out = ok_ff;
   assign i0_out = i0_ff;
   assign i1_out = i1_ff;
   assign t_out  = t_ff;
endmodule
`default_nettype wire

### design/vgts_checker.sv
// port-level checks on the sampler, bound to the top level
`default_nettype none
module vgts_checker (
   input wire clock,
   input wire reset,
   input wire req_valid,
   input wire req_ready,
   input wire rsp_valid,
   input wire rsp_ready,
   input wire [31:0] rsp_density,
   input wire rsp_in_grid
);
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("accepting while a result waits");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_density))
      else $error("result dropped");
   a_out_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_grid |-> rsp_density == 32'd0)
      else $error("outside density");
   a_no_rsp_without_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid) else $error("result too early");
endmodule

bind voxel_grid_trilinear_sampler vgts_checker u_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_density(rsp.payload.density), .rsp_in_grid(rsp.payload.in_grid));
`default_nettype wire

### tb/voxel_grid_trilinear_sampler_tb.sv
// testbench for the voxel grid sampler: directed and random beats against a scoreboard
`timescale 1ns / 1ps
`default_nettype none
module voxel_grid_trilinear_sampler_tb;

   localparam int GRID      = 32;
   localparam int CELLS     = GRID * GRID * GRID;
   localparam int CYCLE_CAP = 2000000;

   // scoreboard: own copy of the grid, the peak and the registers
   class grid_scoreboard;
      logic [31:0]       voxels [CELLS];
      logic [31:0]       peak;
      logic [31:0]       regs [6];
      vgts_pkg::rsp_type awaited [$];
      int                errors;

      function new();
         foreach (voxels[i]) voxels[i] = '0;
         peak = '0;
         regs[vgts_pkg::CSR_ORIGIN_X] = '0;
         regs[vgts_pkg::CSR_ORIGIN_Y] = '0;
         regs[vgts_pkg::CSR_ORIGIN_Z] = '0;
         regs[vgts_pkg::CSR_INV_X] = vgts_pkg::INV_RESET;
         regs[vgts_pkg::CSR_INV_Y] = vgts_pkg::INV_RESET;
         regs[vgts_pkg::CSR_INV_Z] = vgts_pkg::INV_RESET;
         errors = 0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      // one axis: fixed-point grid coordinate, neighbours and fraction
      function bit map_axis(input logic [31:0] pos, input logic [31:0] org,
                            input logic [31:0] inv, output int lo, output int hi,
                            output longint frac);
         longint     rel;
         bit [65:0]  g;
         rel = longint'($signed(pos)) - longint'($signed(org));
         g = '0;
         if (inv != 0) begin
            if (rel < 0) return 0;
            g = (66'(rel) * 66'(inv)) >> 16;
            if (g > (66'(GRID - 1) << 16)) return 0;
         end
         lo   = int'(g >> 16);
         frac = longint'(g[15:0]);
         hi   = (lo + 1 < GRID) ? lo + 1 : GRID - 1;
         return 1;
      endfunction

      // lerp with floor division of the weighted difference
      function longint blend(input longint a, input longint b, input longint t);
         longint p;
         p = (b - a) * t;
         return a + (p >>> 16);
      endfunction

      function longint voxel_at(input int x, input int y, input int z);
         return longint'($signed(voxels[x + GRID * (y + GRID * z)]));
      endfunction

      function void note(input vgts_pkg::req_type r);
         vgts_pkg::rsp_type e;
         bit      in_range;
         int      x0, x1, y0, y1, z0, z1;
         longint  tx, ty, tz, c00, c10, c01, c11, c0, c1, res;
         e = '0;
         in_range = r.x_index < GRID && r.y_index < GRID && r.z_index < GRID;
         case (r.func)
            vgts_pkg::FUNC_WRITE: begin
               if (in_range) begin
                  voxels[r.x_index + GRID * (r.y_index + GRID * r.z_index)] = r.value;
                  if ($signed(r.value) > $signed(peak)) peak = r.value;
                  e.density = r.value;
                  e.in_grid = 1'b1;
               end
            end
            vgts_pkg::FUNC_READ: begin
               if (in_range) begin
                  e.density = voxels[r.x_index + GRID * (r.y_index + GRID * r.z_index)];
                  e.in_grid = 1'b1;
               end
            end
            vgts_pkg::FUNC_SAMPLE: begin
               if (map_axis(r.pos_x, regs[vgts_pkg::CSR_ORIGIN_X],
                            regs[vgts_pkg::CSR_INV_X], x0, x1, tx) &&
                   map_axis(r.pos_y, regs[vgts_pkg::CSR_ORIGIN_Y],
                            regs[vgts_pkg::CSR_INV_Y], y0, y1, ty) &&
                   map_axis(r.pos_z, regs[vgts_pkg::CSR_ORIGIN_Z],
                            regs[vgts_pkg::CSR_INV_Z], z0, z1, tz)) begin
                  c00 = blend(voxel_at(x0, y0, z0), voxel_at(x1, y0, z0), tx);
                  c10 = blend(voxel_at(x0, y1, z0), voxel_at(x1, y1, z0), tx);
                  c01 = blend(voxel_at(x0, y0, z1), voxel_at(x1, y0, z1), tx);
                  c11 = blend(voxel_at(x0, y1, z1), voxel_at(x1, y1, z1), tx);
                  c0  = blend(c00, c10, ty);
                  c1  = blend(c01, c11, ty);
                  res = blend(c0, c1, tz);
                  if (res > 64'sd2147483647) res = 64'sd2147483647;
                  if (res < -64'sd2147483648) res = -64'sd2147483648;
                  e.density = res[31:0];
                  e.in_grid = 1'b1;
               end
            end
            default: begin
               foreach (voxels[i]) voxels[i] = '0;
               peak = '0;
            end
         endcase
         e.max_density = peak;
         awaited.push_back(e);
      endfunction

      task report(input string what, input logic [31:0] got, input logic [31:0] want);
         errors++;
         $display("mismatch %s: got %h, want %h", what, got, want);
      endtask

      task check(input vgts_pkg::rsp_type r);
         vgts_pkg::rsp_type e;
         if (awaited.size() == 0) begin
            report("unexpected beat", r.density, '0);
            return;
         end
         e = awaited.pop_front();
         if (r.density !== e.density) report("density", r.density, e.density);
         if (r.in_grid !== e.in_grid) report("in_grid", 32'(r.in_grid), 32'(e.in_grid));
         if (r.max_density !== e.max_density)
            report("max_density", r.max_density, e.max_density);
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   vgts_if #(.payload_type(vgts_pkg::req_type)) req_ch ();
   vgts_if #(.payload_type(vgts_pkg::rsp_type)) rsp_ch ();

   voxel_grid_trilinear_sampler dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   grid_scoreboard sb = new();

   // 12 ns clock
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // watchdog, sized for the post-reset sweep plus every clear
   int cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("voxel_grid_trilinear_sampler_tb: done, errors");
         $finish;
      end
   end

   // monitors: beats are taken at the edge where valid and ready meet
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) sb.note(req_ch.payload);
      if (!reset && rsp_ch.valid && rsp_ch.ready) sb.check(rsp_ch.payload);
   end

   // receiver: its own stall pattern, plus a long hold-off on request
   bit hold_off_req = 0;
   int hold_left    = 0;
   int rx_mode      = 0;
   int rx_left      = 0;
   initial rsp_ch.ready = 1'b0;
   always @(posedge clock) begin
      if (hold_off_req) begin
         hold_off_req = 0;
         hold_left    = 400;
      end
      if (rx_left == 0) begin
         rx_mode = $urandom_range(0, 2);
         rx_left = $urandom_range(10, 80);
      end
      rx_left--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         case (rx_mode)
            0: rsp_ch.ready <= 1'b1;                     // no stalling
            1: rsp_ch.ready <= ($urandom_range(0, 1) == 0);
            default: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   // sender: bursts of random length with random gaps
   int burst_left = 0;

   task send_beat(input vgts_pkg::req_type r);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if ($urandom_range(0, 3) != 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid   <= 1'b1;
      req_ch.payload <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // stop offering and wait for every awaited result
   task drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   // write enable stays high across back-to-back writes; the caller drops it
   task write_csr(input logic [2:0] idx, input logic [31:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      sb.regs[idx] = data;
      @(posedge clock);
   endtask

   task write_all(input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz,
                  input logic [31:0] ix, input logic [31:0] iy, input logic [31:0] iz);
      write_csr(vgts_pkg::CSR_ORIGIN_X, ox);
      write_csr(vgts_pkg::CSR_ORIGIN_Y, oy);
      write_csr(vgts_pkg::CSR_ORIGIN_Z, oz);
      write_csr(vgts_pkg::CSR_INV_X, ix);
      write_csr(vgts_pkg::CSR_INV_Y, iy);
      write_csr(vgts_pkg::CSR_INV_Z, iz);
      csr_write <= 1'b0;
   endtask

   // position that lands on grid coordinate gq (Q16.16) for this axis setting
   function logic [31:0] aim_pos(input logic [31:0] org, input logic [31:0] inv,
                                 input longint gq);
      longint off;
      if (inv == 0 || $urandom_range(0, 9) == 0) return $urandom;
      off = (gq << 16) / longint'(inv);
      return org + off[31:0] + (($urandom_range(0, 7) == 0) ? 32'd1 : 32'd0);
   endfunction

   function longint pick_coord();
      if ($urandom_range(0, 1) == 0) return longint'($urandom_range(0, 8 * 65536));
      return longint'($urandom_range(0, 31 * 65536 + 4));
   endfunction

   // writes cluster near the low corner and the far corner so samples see data
   function logic [9:0] pick_index();
      case ($urandom_range(0, 9))
         0:       return 10'($urandom);
         1, 2:    return 10'($urandom_range(26, 31));
         default: return 10'($urandom_range(0, 8));
      endcase
   endfunction

   int clears_left = 6;

   function vgts_pkg::req_type make_beat();
      vgts_pkg::req_type r;
      int      pick;
      r = '0;
      r.x_index = pick_index();
      r.y_index = pick_index();
      r.z_index = pick_index();
      r.value   = $urandom;
      r.pos_x   = aim_pos(sb.regs[vgts_pkg::CSR_ORIGIN_X], sb.regs[vgts_pkg::CSR_INV_X],
                          pick_coord());
      r.pos_y   = aim_pos(sb.regs[vgts_pkg::CSR_ORIGIN_Y], sb.regs[vgts_pkg::CSR_INV_Y],
                          pick_coord());
      r.pos_z   = aim_pos(sb.regs[vgts_pkg::CSR_ORIGIN_Z], sb.regs[vgts_pkg::CSR_INV_Z],
                          pick_coord());
      pick = $urandom_range(0, 199);
      if (pick < 70)       r.func = vgts_pkg::FUNC_WRITE;
      else if (pick < 120) r.func = vgts_pkg::FUNC_READ;
      else if (pick < 198 || clears_left == 0) r.func = vgts_pkg::FUNC_SAMPLE;
      else begin
         r.func = vgts_pkg::FUNC_CLEAR;
         clears_left--;
      end
      return r;
   endfunction

   function vgts_pkg::req_type beat(input logic [1:0] f, input int x, input int y,
                                    input int z, input logic [31:0] v,
                                    input logic [31:0] px, input logic [31:0] py,
                                    input logic [31:0] pz);
      vgts_pkg::req_type r;
      r.func = f;
      r.x_index = 10'(x);
      r.y_index = 10'(y);
      r.z_index = 10'(z);
      r.value = v;
      r.pos_x = px;
      r.pos_y = py;
      r.pos_z = pz;
      return r;
   endfunction

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      csr_write      = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      reset          = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes of fields, each operation, edges of the grid
      send_beat(beat(vgts_pkg::FUNC_READ, 5, 5, 5, 0, 0, 0, 0));   // zero after reset
      send_beat(beat(vgts_pkg::FUNC_WRITE, 31, 31, 31, 32'h7fffffff, 0, 0, 0));
      send_beat(beat(vgts_pkg::FUNC_WRITE, 0, 0, 0, 32'h80000000, 0, 0, 0)); // below peak
      send_beat(beat(vgts_pkg::FUNC_WRITE, 30, 31, 31, 32'h00018000, 0, 0, 0));
      send_beat(beat(vgts_pkg::FUNC_WRITE, 1, 0, 0, 32'hffff0000, 0, 0, 0));
      send_beat(beat(vgts_pkg::FUNC_WRITE, 1023, 3, 3, 32'h1234, 0, 0, 0)); // outside
      send_beat(beat(vgts_pkg::FUNC_READ, 3, 32, 3, 0, 0, 0, 0));           // outside
      send_beat(beat(vgts_pkg::FUNC_READ, 3, 3, 1023, 0, 0, 0, 0));
      send_beat(beat(vgts_pkg::FUNC_READ, 31, 31, 31, 0, 0, 0, 0));
      send_beat(beat(vgts_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0));
      // far corner: upper neighbour clamps to the last voxel
      send_beat(beat(vgts_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 31 << 16, 31 << 16, 31 << 16));
      // just past the end
      send_beat(beat(vgts_pkg::FUNC_SAMPLE, 0, 0, 0, 0, (31 << 16) + 1, 0, 0));
      // negative offset
      send_beat(beat(vgts_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 32'hffffffff, 0, 0));
      // half way, positive slope between two negative voxels
      send_beat(beat(vgts_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 32'h00008000, 0, 0));
      send_beat(beat(vgts_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 32'h001e4000, 32'h001fffff,
                     32'h001f0000));
      send_beat(beat(vgts_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 32'h7fffffff, 32'h7fffffff,
                     32'h7fffffff));
      send_beat(beat(vgts_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 32'h80000000, 32'h80000000,
                     32'h80000000));
      send_beat(beat(vgts_pkg::FUNC_CLEAR, 1023, 1023, 1023, 32'hffffffff, 0, 0, 0));
      send_beat(beat(vgts_pkg::FUNC_READ, 31, 31, 31, 0, 0, 0, 0));
      // negative, peak stays 0
      send_beat(beat(vgts_pkg::FUNC_WRITE, 2, 2, 2, 32'hfffe0000, 0, 0, 0));
      send_beat(beat(vgts_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 2 << 16, 2 << 16, 32'h00024000));
      drain();

      // phases of register settings, each followed by random beats
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: ;                                             // reset values
            1: write_all(32'hfffa8000, 32'hff9c0000, 32'h00030000,
                         32'h00010000, 32'h00020000, 32'h00008000);
            2: write_all(32'h80000000, 32'h7fffffff, 32'h00000000,
                         32'h00000000, 32'hffffffff, 32'h00000001);
            3: write_all($urandom, $urandom, $urandom, 0, 0, 0);  // all axes degenerate
            4: write_all($urandom, $urandom, $urandom, $urandom_range(16384, 262144),
                         $urandom_range(16384, 262144), $urandom_range(16384, 262144));
            default: write_all(0, 0, 0, vgts_pkg::INV_RESET, vgts_pkg::INV_RESET,
                               vgts_pkg::INV_RESET);
         endcase
         for (int n = 0; n < 140; n++) begin
            // fill the block while the receiver holds off
            if (phase == 1 && n == 20) hold_off_req = 1;
            send_beat(make_beat());
         end
         drain();
      end

      drain();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("voxel_grid_trilinear_sampler_tb: done, clean");
      else
         $display("voxel_grid_trilinear_sampler_tb: done, errors");
      $finish;
   end
endmodule
`default_nettype wire

### files.f
design/vgts_pkg.sv
design/vgts_if.sv
design/vgts_lerp.sv
design/vgts_axis.sv
design/voxel_grid_trilinear_sampler.sv
design/vgts_checker.sv
tb/voxel_grid_trilinear_sampler_tb.sv
